// ===== design/dqsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dqsc_pkg - shared types and codes for the deque with sort check
// Command, status and cell operation codes, plus the structs passed between
// the top level and the cell chain.
// ----------------------------------------------------------------------------
package dqsc_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // commands on the input stream
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

    // operations broadcast to every cell
    localparam int CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD       = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_PUSH_FRONT = 3'd1;
    localparam logic [CELL_OP_W-1:0] CELL_PUSH_REAR  = 3'd2;
    localparam logic [CELL_OP_W-1:0] CELL_POP_FRONT  = 3'd3;
    localparam logic [CELL_OP_W-1:0] CELL_POP_REAR   = 3'd4;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [CELL_OP_W-1:0] op;
        word_t                value;
    } cell_ctl_t;

    // rear tap passed down the chain: data of the last held cell and
    // whether that cell is smaller than its front-side neighbor
    typedef struct packed {
        word_t data;
        logic  bad;
    } tap_t;

endpackage

// ===== design/dqsc_cell.sv =====
// ----------------------------------------------------------------------------
// dqsc_cell - one entry of the deque chain
// Holds a word and an occupied bit; shifts toward the rear on a front push,
// toward the front on a front pop, and fills or frees itself at the rear.
// ----------------------------------------------------------------------------
module dqsc_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  dqsc_pkg::cell_ctl_t ctl,
    input  dqsc_pkg::word_t   left_data,
    input  logic              left_valid,
    input  dqsc_pkg::word_t   right_data,
    input  logic              right_valid,
    input  dqsc_pkg::tap_t    tap_in,
    output dqsc_pkg::word_t   data,
    output logic              valid,
    output dqsc_pkg::tap_t    tap_out
);

    dqsc_pkg::word_t data_reg;
    dqsc_pkg::word_t data_next;
    logic            valid_reg;
    logic            valid_next;
    logic            is_last;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctl.op)
            dqsc_pkg::CELL_PUSH_FRONT:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            dqsc_pkg::CELL_POP_FRONT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            dqsc_pkg::CELL_PUSH_REAR:
            begin
                // first free cell takes the word
                if (!valid_reg && left_valid)
                begin
                    data_next  = ctl.value;
                    valid_next = 1'b1;
                end
            end
            dqsc_pkg::CELL_POP_REAR:
            begin
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign is_last = valid_reg && !right_valid;

    always_comb
    begin
        tap_out = tap_in;
        if (is_last)
        begin
            tap_out.data = data_reg;
            tap_out.bad  = left_valid && (left_data > data_reg);
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== design/double_ended_queue_with_sort_check.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_sort_check - bounded deque with order check
// Chain of DEPTH cells holding signed words, front at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*) carries one command per transfer: push front, push
//   rear, pop front, pop rear or sorted query, with the word to push.
//   Output stream (m_*) returns exactly one result per command: popped word
//   (-1 on an empty pop), status, empty and sorted flags, entry count.
//   Each command has an accept step and an execute step, in which the whole
//   cell chain shifts or fills in place. The rear word is read through a
//   tap that runs along the chain and is registered every cycle, so it is
//   ready again by the next accept.
//   Order is tracked by a count of out-of-order neighbor pairs, updated
//   only at the ends; sorted means that count is zero.
//   m_tvalid rises at the end of the execute step, once the output register
//   is free; a new command is accepted only after the previous one has
//   executed.
//   A stalled receiver holds the result in the output register; the block
//   accepts one more command, then waits in the execute step with s_tready
//   low until the held result transfers.
//   Reset empties the deque (count 0, front at cell 0); no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_with_sort_check
#(
    parameter int DEPTH = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [2:0] command, [34:3] push_value, [39:35] zero
    input  logic [39:0]             s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [31:0] pop_value, [33:32] status, [34] empty_flag, [35] sorted_flag,
    // entry_count from bit 36 up, rest zero
    output logic [((36+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((36 + CNT_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - 36 - CNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic                          state_reg;
    logic                          state_next;
    logic [dqsc_pkg::CMD_W-1:0]    cmd_reg;
    dqsc_pkg::word_t               value_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              viol_reg;
    logic [CNT_W-1:0]              viol_next;
    dqsc_pkg::tap_t                tap_reg;
    logic                          m_tvalid_reg;
    logic [OUT_W-1:0]              m_tdata_reg;
    logic [OUT_W-1:0]              m_tdata_next;

    dqsc_pkg::cell_ctl_t           ctl;
    dqsc_pkg::word_t               cell_data  [DEPTH];
    logic                          cell_valid [DEPTH];
    dqsc_pkg::tap_t                tap_chain  [DEPTH+1];

    logic                          go;
    logic                          is_full;
    logic                          no_entries;
    logic                          front_bad;
    dqsc_pkg::word_t               pop_value;
    logic [dqsc_pkg::STAT_W-1:0]   status;

    // ---------------- cell chain ----------------
    assign tap_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            dqsc_pkg::word_t l_data;
            logic            l_valid;
            dqsc_pkg::word_t r_data;
            logic            r_valid;

            if (gi == 0)
            begin : g_head
                // a front push feeds the new word in at the head
                assign l_data  = ctl.value;
                assign l_valid = 1'b1;
            end
            else
            begin : g_body
                assign l_data  = cell_data[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid
                assign r_data  = cell_data[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            dqsc_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .tap_in      (tap_chain[gi]),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi]),
                .tap_out     (tap_chain[gi+1])
            );
        end
    endgenerate

    // rear tap sampled every cycle; cells only change on an execute step
    always_ff @(posedge clk)
    begin
        tap_reg <= tap_chain[DEPTH];
    end

    // ---------------- control ----------------
    assign s_tready   = (state_reg == ST_IDLE);
    assign go         = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign is_full    = (count_reg == FULL_CNT);
    assign no_entries = (count_reg == '0);
    assign front_bad  = (count_reg > ONE_CNT) && (cell_data[0] > cell_data[1]);

    always_comb
    begin
        ctl.op     = dqsc_pkg::CELL_HOLD;
        ctl.value  = value_reg;
        count_next = count_reg;
        viol_next  = viol_reg;
        pop_value  = '0;
        status     = dqsc_pkg::STAT_DONE;
        case (cmd_reg)
            dqsc_pkg::CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status = dqsc_pkg::STAT_PUSH_FULL;
                end
                else
                begin
                    ctl.op     = dqsc_pkg::CELL_PUSH_FRONT;
                    count_next = count_reg + ONE_CNT;
                    if (!no_entries && (value_reg > cell_data[0]))
                    begin
                        viol_next = viol_reg + ONE_CNT;
                    end
                end
            end
            dqsc_pkg::CMD_PUSH_REAR:
            begin
                if (is_full)
                begin
                    status = dqsc_pkg::STAT_PUSH_FULL;
                end
                else
                begin
                    ctl.op     = dqsc_pkg::CELL_PUSH_REAR;
                    count_next = count_reg + ONE_CNT;
                    if (!no_entries && (tap_reg.data > value_reg))
                    begin
                        viol_next = viol_reg + ONE_CNT;
                    end
                end
            end
            dqsc_pkg::CMD_POP_FRONT:
            begin
                if (no_entries)
                begin
                    status    = dqsc_pkg::STAT_POP_EMPTY;
                    pop_value = '1;
                end
                else
                begin
                    ctl.op     = dqsc_pkg::CELL_POP_FRONT;
                    count_next = count_reg - ONE_CNT;
                    pop_value  = cell_data[0];
                    if (front_bad)
                    begin
                        viol_next = viol_reg - ONE_CNT;
                    end
                end
            end
            dqsc_pkg::CMD_POP_REAR:
            begin
                if (no_entries)
                begin
                    status    = dqsc_pkg::STAT_POP_EMPTY;
                    pop_value = '1;
                end
                else
                begin
                    ctl.op     = dqsc_pkg::CELL_POP_REAR;
                    count_next = count_reg - ONE_CNT;
                    pop_value  = tap_reg.data;
                    // a lone entry has no pair behind it
                    if ((count_reg > ONE_CNT) && tap_reg.bad)
                    begin
                        viol_next = viol_reg - ONE_CNT;
                    end
                end
            end
            default:
            begin
                ctl.op = dqsc_pkg::CELL_HOLD;
            end
        endcase
        if (!go)
        begin
            ctl.op = dqsc_pkg::CELL_HOLD;
        end
    end

    always_comb
    begin
        m_tdata_next = {{PAD_W{1'b0}}, count_next, (viol_next == '0),
                        (count_next == '0), status, pop_value};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            viol_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                count_reg    <= count_next;
                viol_reg     <= viol_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tdata[2:0];
            value_reg <= s_tdata[34:3];
        end
        if (go)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
